FILE: src/lhie_pkg.sv
// ----------------------------------------------------------------------------
// lhie_pkg: shared types and codes for the linear hash index engine
// Request and result words, node record, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package lhie_pkg;

	// request commands
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_POOL_FULL = 3'd1;
	localparam logic [2:0] ST_DELETED   = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_MATCH     = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_IBL       = 3'd0;
	localparam logic [2:0] REG_LOAD_NUM  = 3'd1;
	localparam logic [2:0] REG_LOAD_DEN  = 3'd2;
	localparam logic [2:0] REG_PANIC_NUM = 3'd3;
	localparam logic [2:0] REG_PANIC_DEN = 3'd4;
	localparam logic [2:0] REG_LAZY      = 3'd5;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] key;
		logic [31:0] page_id;
		logic [15:0] slot_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] page_id_out;
		logic [15:0] slot_id_out;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] page;
		logic [15:0] slot;
	} node_t;

	typedef enum logic [20:0] {
		S_IDLE   = 21'h000001,
		S_CLR    = 21'h000002,
		S_ADDR   = 21'h000004,
		S_INS_RD = 21'h000008,
		S_INS_WR = 21'h000010,
		S_LOAD   = 21'h000020,
		S_CHK    = 21'h000040,
		S_LEN_H  = 21'h000080,
		S_LEN    = 21'h000100,
		S_LEN_N  = 21'h000200,
		S_SPL0   = 21'h000400,
		S_SPL1   = 21'h000800,
		S_SPN    = 21'h001000,
		S_SPA    = 21'h002000,
		S_SPW    = 21'h004000,
		S_SPEND  = 21'h008000,
		S_HEAD   = 21'h010000,
		S_WALK_H = 21'h020000,
		S_WALK   = 21'h040000,
		S_CMP    = 21'h080000,
		S_DEL2   = 21'h100000
	} state_t;

	typedef struct packed {
		state_t     st;
		logic       emit;
		logic [2:0] code;
		logic       from_pend;
		logic       last;
	} ctl_t;

	typedef struct packed {
		logic size_wr;
		logic req_none;
		logic is_ins;
		logic is_del;
		logic fh_nil;
		logic high;
		logic panic;
		logic cnt_ge;
		logic cur_nil;
		logic split_skip;
		logic del_match;
		logic key_match;
		logic k_full;
		logic pend;
		logic clr_last;
	} sts_t;

endpackage

FILE: src/lhie_ram.sv
// ----------------------------------------------------------------------------
// lhie_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lhie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/lhie_ctrl.sv
// ----------------------------------------------------------------------------
// lhie_ctrl: operation sequencer
// Steps each command through its phases and decides every result word.
// ----------------------------------------------------------------------------
module lhie_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lhie_pkg::sts_t    sts,
	output lhie_pkg::ctl_t    ctl,
	output logic              busy
);

	lhie_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lhie_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != lhie_pkg::S_IDLE);

	always_comb begin
		state_d       = state_q;
		ctl.st        = state_q;
		ctl.emit      = 1'b0;
		ctl.code      = lhie_pkg::ST_INSERTED;
		ctl.from_pend = 1'b0;
		ctl.last      = 1'b1;
		case (state_q)
			lhie_pkg::S_IDLE: begin
				if (sts.size_wr) begin
					state_d = lhie_pkg::S_CLR;
				end else if (start && !sts.req_none) begin
					state_d = lhie_pkg::S_ADDR;
				end
			end
			lhie_pkg::S_CLR: begin
				if (sts.clr_last) state_d = lhie_pkg::S_IDLE;
			end
			lhie_pkg::S_ADDR: begin
				state_d = sts.is_ins ? lhie_pkg::S_INS_RD : lhie_pkg::S_HEAD;
			end
			lhie_pkg::S_INS_RD: begin
				if (sts.fh_nil) begin
					ctl.emit = 1'b1;
					ctl.code = lhie_pkg::ST_POOL_FULL;
					state_d  = lhie_pkg::S_IDLE;
				end else begin
					state_d = lhie_pkg::S_INS_WR;
				end
			end
			lhie_pkg::S_INS_WR: state_d = lhie_pkg::S_LOAD;
			lhie_pkg::S_LOAD:   state_d = lhie_pkg::S_CHK;
			lhie_pkg::S_CHK: begin
				if (!sts.high) begin
					ctl.emit = 1'b1;
					state_d  = lhie_pkg::S_IDLE;
				end else if (sts.panic) begin
					state_d = lhie_pkg::S_SPL0;
				end else begin
					state_d = lhie_pkg::S_LEN_H;
				end
			end
			lhie_pkg::S_LEN_H: state_d = lhie_pkg::S_LEN;
			lhie_pkg::S_LEN: begin
				if (sts.cnt_ge) begin
					state_d = lhie_pkg::S_SPL0;
				end else if (sts.cur_nil) begin
					ctl.emit = 1'b1;
					state_d  = lhie_pkg::S_IDLE;
				end else begin
					state_d = lhie_pkg::S_LEN_N;
				end
			end
			lhie_pkg::S_LEN_N: state_d = lhie_pkg::S_LEN;
			lhie_pkg::S_SPL0: begin
				if (sts.split_skip) begin
					ctl.emit = 1'b1;
					state_d  = lhie_pkg::S_IDLE;
				end else begin
					state_d = lhie_pkg::S_SPL1;
				end
			end
			lhie_pkg::S_SPL1: state_d = lhie_pkg::S_SPN;
			lhie_pkg::S_SPN: begin
				state_d = sts.cur_nil ? lhie_pkg::S_SPEND : lhie_pkg::S_SPA;
			end
			lhie_pkg::S_SPA: state_d = lhie_pkg::S_SPW;
			lhie_pkg::S_SPW: state_d = lhie_pkg::S_SPN;
			lhie_pkg::S_SPEND: begin
				ctl.emit = 1'b1;
				state_d  = lhie_pkg::S_IDLE;
			end
			lhie_pkg::S_HEAD:   state_d = lhie_pkg::S_WALK_H;
			lhie_pkg::S_WALK_H: state_d = lhie_pkg::S_WALK;
			lhie_pkg::S_WALK: begin
				if (sts.cur_nil) begin
					ctl.emit = 1'b1;
					state_d  = lhie_pkg::S_IDLE;
					if (!sts.is_del && sts.pend) begin
						ctl.code      = lhie_pkg::ST_MATCH;
						ctl.from_pend = 1'b1;
					end else begin
						ctl.code = lhie_pkg::ST_NOT_FOUND;
					end
				end else begin
					state_d = lhie_pkg::S_CMP;
				end
			end
			lhie_pkg::S_CMP: begin
				state_d = lhie_pkg::S_WALK;
				if (sts.is_del) begin
					if (sts.del_match) state_d = lhie_pkg::S_DEL2;
				end else if (sts.key_match) begin
					if (sts.k_full) begin
						ctl.emit      = 1'b1;
						ctl.code      = lhie_pkg::ST_TRUNC;
						ctl.from_pend = 1'b1;
						state_d       = lhie_pkg::S_IDLE;
					end else if (sts.pend) begin
						ctl.emit      = 1'b1;
						ctl.code      = lhie_pkg::ST_MATCH;
						ctl.from_pend = 1'b1;
						ctl.last      = 1'b0;
					end
				end
			end
			lhie_pkg::S_DEL2: begin
				ctl.emit = 1'b1;
				ctl.code = lhie_pkg::ST_DELETED;
				state_d  = lhie_pkg::S_IDLE;
			end
			default: state_d = lhie_pkg::S_IDLE;
		endcase
	end

endmodule

FILE: src/lhie_dp.sv
// ----------------------------------------------------------------------------
// lhie_dp: table datapath
// Bucket head, link and node RAMs, table registers, address math and the
// result register.
// ----------------------------------------------------------------------------
module lhie_dp #(
	parameter int NODE_POOL   = 1024,
	parameter int MAX_BUCKETS = 1024,
	parameter int MAX_MATCHES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lhie_pkg::req_t request,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [10:0]    cfg_data,
	input  lhie_pkg::ctl_t ctl,
	output lhie_pkg::sts_t sts,
	output logic           result_valid,
	output lhie_pkg::rsp_t result
);

	localparam int NW    = $clog2(NODE_POOL + 1);
	localparam int NAW   = $clog2(NODE_POOL);
	localparam int BW    = $clog2(MAX_BUCKETS);
	localparam int LW    = $clog2(MAX_BUCKETS + 1);
	localparam int MBL   = $clog2(MAX_BUCKETS + 1) - 1;
	localparam int AW    = MBL + 3;
	localparam int EW    = $clog2(MBL + 3);
	localparam int KW    = $clog2(MAX_MATCHES + 1);
	localparam int CNTW  = (NW > 11) ? NW : 11;
	localparam int PW    = ((NW > LW) ? NW : LW) + 8;
	localparam int CLR_N = (NODE_POOL > MAX_BUCKETS) ? NODE_POOL : MAX_BUCKETS;
	localparam int CLRW  = $clog2(CLR_N);
	localparam logic [NW-1:0] NIL = NW'(NODE_POOL);

	// configuration
	logic [3:0]  ibl_q;
	logic [7:0]  ln_q, ld_q, pn_q, pd_q;
	logic [10:0] lazy_q;

	// table registers
	lhie_pkg::req_t  req_q;
	logic [BW-1:0]   b_q, sp_q, a_q;
	logic [NW-1:0]   fh_q, rc_q, cur_q, prev_q, nx_q;
	logic [LW-1:0]   lb_q;
	logic [EW-1:0]   e_q;
	logic [CNTW-1:0] cnt_q;
	logic            high_q, panic_q;
	logic [KW-1:0]   k_q;
	logic            pend_q;
	logic [31:0]     pend_pg_q;
	logic [15:0]     pend_sl_q;
	logic [CLRW-1:0] clr_q;

	// RAM ports
	logic              h_we, l_we, n_we;
	logic [BW-1:0]     h_wa, h_ra;
	logic [NW-1:0]     h_wd, h_rd, l_wd, l_rd;
	logic [NAW-1:0]    l_wa, l_ra, n_wa, n_ra;
	lhie_pkg::node_t   n_wd, n_rd;

	lhie_ram #(.WIDTH(NW), .DEPTH(MAX_BUCKETS)) u_heads (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
	);
	lhie_ram #(.WIDTH(NW), .DEPTH(NODE_POOL)) u_links (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
	);
	lhie_ram #(.WIDTH($bits(lhie_pkg::node_t)), .DEPTH(NODE_POOL)) u_nodes (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
	);

	// address math
	logic [EW-1:0] il;
	logic [AW-1:0] mask1, mask2, key_lo, a1, r_w, nb_w, sa_w;
	logic [BW-1:0] b_c, nb, sa;
	logic          wrap, is_del;

	assign il     = (32'(ibl_q) > MBL) ? EW'(MBL) : EW'(ibl_q);
	assign mask1  = ~({AW{1'b1}} << e_q);
	assign mask2  = ~({AW{1'b1}} << (e_q + EW'(1)));
	assign key_lo = req_q.key[AW-1:0];
	assign r_w    = AW'(1) << e_q;
	assign nb_w   = AW'(sp_q) + r_w;
	assign nb     = nb_w[BW-1:0];
	assign wrap   = (AW'(sp_q) + AW'(1)) >= r_w;
	assign sa_w   = n_rd.key[AW-1:0] & mask2;
	assign sa     = (sa_w >= AW'(MAX_BUCKETS)) ? sp_q : sa_w[BW-1:0];
	assign is_del = (req_q.command == lhie_pkg::CMD_DELETE);

	always_comb begin
		a1 = key_lo & mask1;
		if (a1 < AW'(sp_q)) a1 = key_lo & mask2;
		b_c = (a1 >= AW'(MAX_BUCKETS)) ? '0 : a1[BW-1:0];
	end

	// status to the sequencer
	always_comb begin
		sts.size_wr    = cfg_we && (cfg_index == lhie_pkg::REG_IBL);
		sts.req_none   = (request.command == lhie_pkg::CMD_NONE);
		sts.is_ins     = (req_q.command == lhie_pkg::CMD_INSERT);
		sts.is_del     = is_del;
		sts.fh_nil     = (fh_q == NIL);
		sts.high       = high_q;
		sts.panic      = panic_q;
		sts.cnt_ge     = cnt_q >= CNTW'(lazy_q);
		sts.cur_nil    = (cur_q == NIL);
		sts.split_skip = nb_w >= AW'(MAX_BUCKETS);
		sts.del_match  = (n_rd.key == req_q.key) && (n_rd.page == req_q.page_id)
		                 && (n_rd.slot == req_q.slot_id);
		sts.key_match  = (n_rd.key == req_q.key);
		sts.k_full     = (k_q == KW'(MAX_MATCHES));
		sts.pend       = pend_q;
		sts.clr_last   = (clr_q == CLRW'(CLR_N - 1));
	end

	// RAM port steering
	always_comb begin
		h_we = 1'b0; h_wa = '0; h_wd = NIL; h_ra = '0;
		l_we = 1'b0; l_wa = '0; l_wd = NIL; l_ra = '0;
		n_we = 1'b0; n_wa = '0; n_ra = '0;
		n_wd = '{key: req_q.key, page: req_q.page_id, slot: req_q.slot_id};
		case (ctl.st)
			lhie_pkg::S_CLR: begin
				h_we = 32'(clr_q) < MAX_BUCKETS;
				h_wa = clr_q[BW-1:0];
				l_we = 32'(clr_q) < NODE_POOL;
				l_wa = clr_q[NAW-1:0];
				l_wd = NW'(clr_q) + NW'(1);
			end
			lhie_pkg::S_INS_RD: begin
				h_ra = b_q;
				l_ra = fh_q[NAW-1:0];
			end
			lhie_pkg::S_INS_WR: begin
				n_we = 1'b1; n_wa = fh_q[NAW-1:0];
				l_we = 1'b1; l_wa = fh_q[NAW-1:0]; l_wd = h_rd;
				h_we = 1'b1; h_wa = b_q; h_wd = fh_q;
			end
			lhie_pkg::S_CHK: h_ra = sp_q;
			lhie_pkg::S_LEN: l_ra = cur_q[NAW-1:0];
			lhie_pkg::S_SPL0: begin
				h_ra = sp_q;
				h_we = !sts.split_skip; h_wa = nb;
			end
			lhie_pkg::S_SPL1: begin
				h_we = 1'b1; h_wa = sp_q;
			end
			lhie_pkg::S_SPN, lhie_pkg::S_WALK: begin
				n_ra = cur_q[NAW-1:0];
				l_ra = cur_q[NAW-1:0];
			end
			lhie_pkg::S_SPA: h_ra = sa;
			lhie_pkg::S_SPW: begin
				l_we = 1'b1; l_wa = cur_q[NAW-1:0]; l_wd = h_rd;
				h_we = 1'b1; h_wa = a_q; h_wd = cur_q;
			end
			lhie_pkg::S_HEAD: h_ra = b_q;
			lhie_pkg::S_CMP: begin
				if (is_del && sts.del_match) begin
					if (prev_q == NIL) begin
						h_we = 1'b1; h_wa = b_q; h_wd = l_rd;
					end else begin
						l_we = 1'b1; l_wa = prev_q[NAW-1:0]; l_wd = l_rd;
					end
				end
			end
			lhie_pkg::S_DEL2: begin
				l_we = 1'b1; l_wa = cur_q[NAW-1:0]; l_wd = fh_q;
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibl_q  <= 4'd7;
			ln_q   <= 8'd3;
			ld_q   <= 8'd4;
			pn_q   <= 8'd2;
			pd_q   <= 8'd1;
			lazy_q <= 11'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				lhie_pkg::REG_IBL:       ibl_q  <= cfg_data[3:0];
				lhie_pkg::REG_LOAD_NUM:  ln_q   <= cfg_data[7:0];
				lhie_pkg::REG_LOAD_DEN:  ld_q   <= cfg_data[7:0];
				lhie_pkg::REG_PANIC_NUM: pn_q   <= cfg_data[7:0];
				lhie_pkg::REG_PANIC_DEN: pd_q   <= cfg_data[7:0];
				lhie_pkg::REG_LAZY:      lazy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// table control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			fh_q  <= '0;
			rc_q  <= '0;
			sp_q  <= '0;
			lb_q  <= '0;
			e_q   <= '0;
		end else begin
			case (ctl.st)
				lhie_pkg::S_CLR: begin
					clr_q <= sts.clr_last ? '0 : clr_q + CLRW'(1);
					fh_q  <= '0;
					rc_q  <= '0;
					sp_q  <= '0;
					e_q   <= il;
					lb_q  <= LW'(1) << il;
				end
				lhie_pkg::S_INS_WR: begin
					fh_q <= l_rd;
					rc_q <= rc_q + NW'(1);
				end
				lhie_pkg::S_SPEND: begin
					lb_q <= lb_q + LW'(1);
					if (wrap) begin
						sp_q <= '0;
						e_q  <= e_q + EW'(1);
					end else begin
						sp_q <= sp_q + BW'(1);
					end
				end
				lhie_pkg::S_DEL2: begin
					fh_q <= cur_q;
					if (rc_q != '0) rc_q <= rc_q - NW'(1);
				end
				default: ;
			endcase
		end
	end

	// walk and work registers
	always_ff @(posedge clk) begin
		case (ctl.st)
			lhie_pkg::S_IDLE: begin
				if (start) req_q <= request;
			end
			lhie_pkg::S_ADDR: b_q <= b_c;
			lhie_pkg::S_LOAD: begin
				high_q  <= PW'(rc_q) * PW'(ld_q) > PW'(lb_q) * PW'(ln_q);
				panic_q <= PW'(rc_q) * PW'(pd_q) > PW'(lb_q) * PW'(pn_q);
			end
			lhie_pkg::S_CHK: cnt_q <= '0;
			lhie_pkg::S_LEN: begin
				if (!sts.cnt_ge && !sts.cur_nil) cnt_q <= cnt_q + CNTW'(1);
			end
			lhie_pkg::S_LEN_H, lhie_pkg::S_SPL1, lhie_pkg::S_WALK_H: cur_q <= h_rd;
			lhie_pkg::S_LEN_N: cur_q <= l_rd;
			lhie_pkg::S_SPA: begin
				a_q  <= sa;
				nx_q <= l_rd;
			end
			lhie_pkg::S_SPW: cur_q <= nx_q;
			lhie_pkg::S_HEAD: begin
				prev_q <= NIL;
				k_q    <= '0;
				pend_q <= 1'b0;
			end
			lhie_pkg::S_CMP: begin
				if (!(is_del && sts.del_match)) begin
					prev_q <= cur_q;
					cur_q  <= l_rd;
				end
				if (!is_del && sts.key_match && !sts.k_full) begin
					pend_q    <= 1'b1;
					pend_pg_q <= n_rd.page;
					pend_sl_q <= n_rd.slot;
					k_q       <= k_q + KW'(1);
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		result.status      <= ctl.code;
		result.page_id_out <= ctl.from_pend ? pend_pg_q : 32'd0;
		result.slot_id_out <= ctl.from_pend ? pend_sl_q : 16'd0;
		result.last        <= ctl.last;
	end

endmodule

FILE: src/linear_hash_index_engine.sv
// ----------------------------------------------------------------------------
// linear_hash_index_engine: linear-hashing record index
// Chained buckets over a fixed node pool; insert with lazy or panic split,
// delete of the first exact match, lookup of up to MAX_MATCHES in chain order.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                Word
// -------   ----------------------   -------------------------------------
// request   start & !busy            command, key, page_id, slot_id
// result    result_valid (1 cycle)   status, page_id_out, slot_id_out, last
// config    cfg_we                   cfg_index, cfg_data
//
// Insert pops the free-list head and links the node at its bucket head; an
// empty pool ends it with ST_POOL_FULL. Above the load limit it splits at
// once when also above the panic limit, else it counts the chain at the
// split pointer and splits once that reaches the lazy length. A split,
// skipped when the bucket array is full, rehashes each node of the bucket.
// Delete and lookup walk the chain with one registered link and node RAM
// read per step; lookup holds each match until the next one or chain end.
// Reset, or a write of initial_bucket_log2 while idle, starts a clearing
// pass over max(NODE_POOL, MAX_BUCKETS) head and link addresses; busy holds
// high meanwhile. Results cannot be stalled: each word shows for one cycle.
//
module linear_hash_index_engine #(
	parameter int NODE_POOL   = 1024,
	parameter int MAX_BUCKETS = 1024,
	parameter int MAX_MATCHES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lhie_pkg::req_t request,
	output logic           result_valid,
	output lhie_pkg::rsp_t result,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [10:0]    cfg_data
);

	// command and status between sequencer and datapath
	lhie_pkg::ctl_t ctl;
	lhie_pkg::sts_t sts;

	// sequencer: walks each command through its phases, decides result words
	lhie_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	// datapath: RAMs, table registers, bucket address math, result register
	lhie_dp #(
		.NODE_POOL   (NODE_POOL),
		.MAX_BUCKETS (MAX_BUCKETS),
		.MAX_MATCHES (MAX_MATCHES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.request      (request),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ctl          (ctl),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
